>>> rtl/plu_pkg.sv
// Shared types, constants and helpers for the particle leapfrog update pipeline.
package plu_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int WIDE_W = 64;
    localparam int CFG_W = 31;
    localparam int IDX_W = 3;

    localparam int SQRT_STEPS = DATA_W;
    localparam int DIV_STEPS = DATA_W;
    localparam int PIPE_DEPTH = 3 + SQRT_STEPS + DIV_STEPS + 5 + DIV_STEPS + 1;

    typedef logic [DATA_W-1:0] word_t;
    typedef word_t [2:0] vec_t;
    typedef logic [WIDE_W-1:0] dword_t;
    typedef dword_t [2:0] dvec_t;

    typedef enum logic [IDX_W-1:0] {
        REG_TIME_STEP   = 3'd0,
        REG_GRAVITY_Z   = 3'd1,
        REG_FORCE_LIMIT = 3'd2,
        REG_FLOCK_GAIN  = 3'd3,
        REG_WORLD_SCALE = 3'd4
    } cfg_reg_t;

    localparam logic signed [WIDE_W-1:0] WORD_MAX = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam logic signed [WIDE_W-1:0] WORD_MIN = -(64'sd1 <<< (DATA_W - 1));

    typedef struct packed {
        vec_t   p;
        vec_t   v;
        vec_t   f;
        dvec_t  gc;
    } stg_a_t;

    typedef struct packed {
        vec_t   p;
        vec_t   v;
        vec_t   f;
        dvec_t  gc;
        dvec_t  sq;
        dvec_t  ml;
        dword_t lsq;
    } stg_b_t;

    typedef struct packed {
        vec_t   p;
        vec_t   v;
        vec_t   f;
        dvec_t  gc;
        dvec_t  ml;
        logic   limit;
    } stg_c_t;

    typedef struct packed {
        vec_t   p;
        vec_t   v;
        vec_t   f;
        dvec_t  gc;
        logic   limit;
    } stg_d_t;

    typedef struct packed {
        vec_t   p;
        vec_t   v;
        dvec_t  gc;
        dvec_t  dtf;
    } stg_e_t;

    typedef struct packed {
        vec_t   p;
        vec_t   v;
        vec_t   vn;
    } stg_f_t;

    typedef struct packed {
        vec_t   p;
        vec_t   vn;
        vec_t   mid;
        dvec_t  dtv;
    } stg_g_t;

    typedef struct packed {
        vec_t   vn;
        vec_t   mid;
        dvec_t  q;
    } stg_h_t;

    typedef struct packed {
        vec_t       vn;
        vec_t       mid;
        logic [2:0] neg;
        logic [2:0] ovf;
    } stg_i_t;

    typedef struct packed {
        vec_t   npos;
        vec_t   vn;
        vec_t   mid;
    } out_t;

    function automatic word_t sat_word(input logic signed [WIDE_W-1:0] x);
        word_t r;
        if (x > WORD_MAX)
        begin
            r = WORD_MAX[DATA_W-1:0];
        end
        else if (x < WORD_MIN)
        begin
            r = WORD_MIN[DATA_W-1:0];
        end
        else
        begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/plu_isqrt.sv
// Pipelined integer square root, one root bit resolved per stage.
module plu_isqrt (
    input  logic                  clk,
    input  logic                  en,
    input  plu_pkg::dword_t       rad,
    output plu_pkg::word_t        root
);
    import plu_pkg::*;

    localparam int REM_W = DATA_W + 2;
    localparam int CUR_W = DATA_W + 4;

    logic [REM_W-1:0]  rem_reg [SQRT_STEPS];
    word_t             root_reg [SQRT_STEPS];
    dword_t            rad_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic [REM_W-1:0] rem_in;
        word_t            root_in;
        dword_t           rad_in;
        logic [CUR_W-1:0] cur;
        logic [CUR_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign root_in = '0;
            assign rad_in = rad;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in = rad_reg[k-1];
        end

        assign cur = {rem_in, rad_in[WIDE_W-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cur >= trial)
                begin
                    rem_reg[k] <= REM_W'(cur - trial);
                    root_reg[k] <= {root_in[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= cur[REM_W-1:0];
                    root_reg[k] <= {root_in[DATA_W-2:0], 1'b0};
                end
                rad_reg[k] <= {rad_in[WIDE_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

>>> rtl/plu_div.sv
// Pipelined restoring divider, one quotient bit per stage, high dividend half below divisor.
module plu_div (
    input  logic             clk,
    input  logic             en,
    input  plu_pkg::word_t   num_hi,
    input  plu_pkg::word_t   num_lo,
    input  plu_pkg::word_t   den,
    output plu_pkg::word_t   quo
);
    import plu_pkg::*;

    word_t rem_reg [DIV_STEPS];
    word_t lo_reg [DIV_STEPS];
    word_t quo_reg [DIV_STEPS];
    word_t den_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        word_t           rem_in;
        word_t           lo_in;
        word_t           quo_in;
        word_t           den_in;
        logic [DATA_W:0] cur;
        logic            ge;

        if (k == 0)
        begin : g_first
            assign rem_in = num_hi;
            assign lo_in = num_lo;
            assign quo_in = '0;
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign lo_in = lo_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign cur = {rem_in, lo_in[DATA_W-1]};
        assign ge = cur >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (ge)
                begin
                    rem_reg[k] <= DATA_W'(cur - {1'b0, den_in});
                end
                else
                begin
                    rem_reg[k] <= cur[DATA_W-1:0];
                end
                lo_reg[k] <= {lo_in[DATA_W-2:0], 1'b0};
                quo_reg[k] <= {quo_in[DATA_W-2:0], ge};
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

>>> rtl/particle_leapfrog_update.sv
// Top level of the particle leapfrog update pipeline.
// One item is accepted per cycle while the skid register is empty and in_ready is high;
// the square root and both divider banks are fully pipelined.
// A skid register behind the last stage lets one more item in while a result waits.
// Reset clears all valid bits and loads the register defaults; no item is in flight afterward.
module particle_leapfrog_update (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [31:0]        pos_x,
    input  logic signed [31:0]        pos_y,
    input  logic signed [31:0]        pos_z,
    input  logic signed [31:0]        vel_x,
    input  logic signed [31:0]        vel_y,
    input  logic signed [31:0]        vel_z,
    input  logic signed [31:0]        force_x,
    input  logic signed [31:0]        force_y,
    input  logic signed [31:0]        force_z,
    input  logic signed [31:0]        flock_x,
    input  logic signed [31:0]        flock_y,
    input  logic signed [31:0]        flock_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [31:0]        new_pos_x,
    output logic signed [31:0]        new_pos_y,
    output logic signed [31:0]        new_pos_z,
    output logic signed [31:0]        new_vel_x,
    output logic signed [31:0]        new_vel_y,
    output logic signed [31:0]        new_vel_z,
    output logic signed [31:0]        mid_vel_x,
    output logic signed [31:0]        mid_vel_y,
    output logic signed [31:0]        mid_vel_z,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [31:0]               cfg_data
);
    import plu_pkg::*;

    logic [CFG_W-1:0]         time_step_reg;
    logic signed [DATA_W-1:0] gravity_z_reg;
    logic [CFG_W-1:0]         force_limit_reg;
    logic signed [DATA_W-1:0] flock_gain_reg;
    logic [CFG_W-1:0]         world_scale_reg;
    logic [CFG_W-1:0]         scale;

    logic                  en;
    logic [PIPE_DEPTH-1:0] vld_reg;

    vec_t   in_p;
    vec_t   in_v;
    vec_t   in_f;
    vec_t   in_c;

    stg_a_t a_next;
    stg_a_t a_reg;
    stg_b_t b_next;
    stg_b_t b_reg;
    stg_c_t c_next;
    stg_c_t c_reg;
    dword_t c_sum_next;
    dword_t c_sum_reg;

    word_t  root;
    stg_c_t sqrt_line [SQRT_STEPS];
    stg_c_t sqrt_side;
    stg_d_t d_in;
    stg_d_t d_line [DIV_STEPS];
    stg_d_t d_side;
    vec_t   fquo;

    stg_e_t e_next;
    stg_e_t e_reg;
    stg_f_t f_next;
    stg_f_t f_reg;
    stg_g_t g_next;
    stg_g_t g_reg;
    stg_h_t h_next;
    stg_h_t h_reg;
    stg_i_t i_next;
    stg_i_t i_reg;
    vec_t   i_hi_next;
    vec_t   i_hi_reg;
    vec_t   i_lo_next;
    vec_t   i_lo_reg;

    stg_i_t pos_line [DIV_STEPS];
    stg_i_t pos_side;
    vec_t   pquo;

    out_t   p_next;
    out_t   p_reg;
    out_t   skid_reg;
    logic   skid_valid_reg;
    out_t   out_sel;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= 31'd655;
            gravity_z_reg <= '0;
            force_limit_reg <= 31'd65536;
            flock_gain_reg <= 32'sd65536;
            world_scale_reg <= 31'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TIME_STEP:   time_step_reg <= cfg_data[CFG_W-1:0];
                REG_GRAVITY_Z:   gravity_z_reg <= cfg_data;
                REG_FORCE_LIMIT: force_limit_reg <= cfg_data[CFG_W-1:0];
                REG_FLOCK_GAIN:  flock_gain_reg <= cfg_data;
                REG_WORLD_SCALE: world_scale_reg <= cfg_data[CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign scale = (world_scale_reg == '0) ? CFG_W'(1) : world_scale_reg;

    assign en = !skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    assign in_p = {pos_z, pos_y, pos_x};
    assign in_v = {vel_z, vel_y, vel_x};
    assign in_f = {force_z, force_y, force_x};
    assign in_c = {flock_z, flock_y, flock_x};

    always_comb
    begin
        logic [DATA_W:0] fz_sum;
        a_next.p = in_p;
        a_next.v = in_v;
        a_next.f = in_f;
        fz_sum = {gravity_z_reg[DATA_W-1], gravity_z_reg} + {in_f[2][DATA_W-1], in_f[2]};
        if (fz_sum[DATA_W] != fz_sum[DATA_W-1])
        begin
            a_next.f[2] = fz_sum[DATA_W] ? WORD_MIN[DATA_W-1:0] : WORD_MAX[DATA_W-1:0];
        end
        else
        begin
            a_next.f[2] = fz_sum[DATA_W-1:0];
        end
        for (int i = 0; i < 3; i++)
        begin
            a_next.gc[i] = WIDE_W'(flock_gain_reg) * WIDE_W'($signed(in_c[i]));
        end
    end

    always_comb
    begin
        word_t mag;
        b_next.p = a_reg.p;
        b_next.v = a_reg.v;
        b_next.f = a_reg.f;
        b_next.gc = a_reg.gc;
        b_next.lsq = WIDE_W'(force_limit_reg) * WIDE_W'(force_limit_reg);
        for (int i = 0; i < 3; i++)
        begin
            mag = a_reg.f[i][DATA_W-1] ? DATA_W'(-a_reg.f[i]) : a_reg.f[i];
            b_next.sq[i] = WIDE_W'(mag) * WIDE_W'(mag);
            b_next.ml[i] = WIDE_W'(mag) * WIDE_W'(force_limit_reg);
        end
    end

    always_comb
    begin
        c_sum_next = b_reg.sq[0] + b_reg.sq[1] + b_reg.sq[2];
        c_next.p = b_reg.p;
        c_next.v = b_reg.v;
        c_next.f = b_reg.f;
        c_next.gc = b_reg.gc;
        c_next.ml = b_reg.ml;
        c_next.limit = c_sum_next > b_reg.lsq;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            c_sum_reg <= c_sum_next;
        end
    end

    plu_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  (c_sum_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqrt_line[0] <= c_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                sqrt_line[k] <= sqrt_line[k-1];
            end
        end
    end

    assign sqrt_side = sqrt_line[SQRT_STEPS-1];

    for (genvar i = 0; i < 3; i++)
    begin : g_fdiv
        plu_div u_fdiv (
            .clk    (clk),
            .en     (en),
            .num_hi (sqrt_side.ml[i][WIDE_W-1:DATA_W]),
            .num_lo (sqrt_side.ml[i][DATA_W-1:0]),
            .den    (root),
            .quo    (fquo[i])
        );
    end

    always_comb
    begin
        d_in.p = sqrt_side.p;
        d_in.v = sqrt_side.v;
        d_in.f = sqrt_side.f;
        d_in.gc = sqrt_side.gc;
        d_in.limit = sqrt_side.limit;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_line[0] <= d_in;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                d_line[k] <= d_line[k-1];
            end
        end
    end

    assign d_side = d_line[DIV_STEPS-1];

    always_comb
    begin
        word_t flim;
        e_next.p = d_side.p;
        e_next.v = d_side.v;
        e_next.gc = d_side.gc;
        for (int i = 0; i < 3; i++)
        begin
            if (d_side.limit)
            begin
                flim = d_side.f[i][DATA_W-1] ? DATA_W'(-fquo[i]) : fquo[i];
            end
            else
            begin
                flim = d_side.f[i];
            end
            e_next.dtf[i] = WIDE_W'($signed({1'b0, time_step_reg})) * WIDE_W'($signed(flim));
        end
    end

    always_comb
    begin
        logic signed [WIDE_W-1:0] vsum;
        f_next.p = e_reg.p;
        f_next.v = e_reg.v;
        for (int i = 0; i < 3; i++)
        begin
            vsum = WIDE_W'($signed(e_reg.v[i])) + ($signed(e_reg.dtf[i]) >>> FRAC_W)
                 + ($signed(e_reg.gc[i]) >>> FRAC_W);
            f_next.vn[i] = sat_word(vsum);
        end
    end

    always_comb
    begin
        logic signed [DATA_W:0] msum;
        g_next.p = f_reg.p;
        g_next.vn = f_reg.vn;
        for (int i = 0; i < 3; i++)
        begin
            g_next.dtv[i] = WIDE_W'($signed({1'b0, time_step_reg})) * WIDE_W'($signed(f_reg.vn[i]));
            msum = (DATA_W+1)'($signed(f_reg.v[i])) + (DATA_W+1)'($signed(f_reg.vn[i]));
            g_next.mid[i] = msum[DATA_W:1];
        end
    end

    always_comb
    begin
        h_next.vn = g_reg.vn;
        h_next.mid = g_reg.mid;
        for (int i = 0; i < 3; i++)
        begin
            h_next.q[i] = WIDE_W'($signed(g_reg.p[i])) + ($signed(g_reg.dtv[i]) >>> FRAC_W);
        end
    end

    always_comb
    begin
        dword_t magq;
        dword_t num;
        i_next.vn = h_reg.vn;
        i_next.mid = h_reg.mid;
        for (int i = 0; i < 3; i++)
        begin
            i_next.neg[i] = h_reg.q[i][WIDE_W-1];
            magq = h_reg.q[i][WIDE_W-1] ? WIDE_W'(-h_reg.q[i]) : h_reg.q[i];
            num = magq << FRAC_W;
            i_hi_next[i] = num[WIDE_W-1:DATA_W];
            i_lo_next[i] = num[DATA_W-1:0];
            i_next.ovf[i] = num[WIDE_W-1:DATA_W] >= {1'b0, scale};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg <= e_next;
            f_reg <= f_next;
            g_reg <= g_next;
            h_reg <= h_next;
            i_reg <= i_next;
            i_hi_reg <= i_hi_next;
            i_lo_reg <= i_lo_next;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_pdiv
        plu_div u_pdiv (
            .clk    (clk),
            .en     (en),
            .num_hi (i_hi_reg[i]),
            .num_lo (i_lo_reg[i]),
            .den    ({1'b0, scale}),
            .quo    (pquo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_line[0] <= i_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                pos_line[k] <= pos_line[k-1];
            end
        end
    end

    assign pos_side = pos_line[DIV_STEPS-1];

    always_comb
    begin
        logic big;
        p_next.vn = pos_side.vn;
        p_next.mid = pos_side.mid;
        for (int i = 0; i < 3; i++)
        begin
            big = pos_side.ovf[i] || pquo[i][DATA_W-1];
            if (pos_side.neg[i])
            begin
                p_next.npos[i] = big ? WORD_MIN[DATA_W-1:0] : DATA_W'(-pquo[i]);
            end
            else
            begin
                p_next.npos[i] = big ? WORD_MAX[DATA_W-1:0] : pquo[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (vld_reg[PIPE_DEPTH-1] && !out_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_reg <= p_reg;
        end
    end

    assign out_sel = skid_valid_reg ? skid_reg : p_reg;
    assign out_valid = skid_valid_reg || vld_reg[PIPE_DEPTH-1];

    assign new_pos_x = out_sel.npos[0];
    assign new_pos_y = out_sel.npos[1];
    assign new_pos_z = out_sel.npos[2];
    assign new_vel_x = out_sel.vn[0];
    assign new_vel_y = out_sel.vn[1];
    assign new_vel_z = out_sel.vn[2];
    assign mid_vel_x = out_sel.mid[0];
    assign mid_vel_y = out_sel.mid[1];
    assign mid_vel_z = out_sel.mid[2];

endmodule

>>> rtl/plu_checker.sv
// Port-level assertions for the particle leapfrog update, bound to the top level.
module plu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] new_pos_x,
    input logic signed [31:0] new_vel_x,
    input logic signed [31:0] mid_vel_x
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Output item dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(new_pos_x) && $stable(new_vel_x)
            && $stable(mid_vel_x))
        else $error("Output item changed while stalled.");

    a_ready_low_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("Input blocked with no result waiting.");

    a_ready_fall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("Input blocked without an output stall.");

endmodule

bind particle_leapfrog_update plu_checker u_plu_checker (.*);
